FILE: design/rkt_pkg.sv
// Shared constants, codes and control types for the reference-counted key table.
package rkt_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_UPDATE = 2'd2;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_MISSING   = 2'd1;
    localparam logic [1:0] STAT_DUPLICATE = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } rkt_state_t;

    typedef struct packed
    {
        logic start;
        logic scan;
        logic finish;
    } rkt_cmd_t;

    typedef struct packed
    {
        logic match;
        logic last;
    } rkt_stat_t;

endpackage

FILE: design/rkt_req_if.sv
// Request channel: one beat carries an operation on the table.
interface rkt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [63:0]        key;
    logic [63:0]        ext_value;
    logic signed [31:0] delta;

    modport source
    (
        output valid, func, key, ext_value, delta,
        input  ready
    );

    modport sink
    (
        input  valid, func, key, ext_value, delta,
        output ready
    );
endinterface

FILE: design/rkt_rsp_if.sv
// Response channel: one beat carries the outcome of one operation.
interface rkt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] ext_out;
    logic [63:0] count_out;
    logic        freed;

    modport source
    (
        output valid, status, ext_out, count_out, freed,
        input  ready
    );

    modport sink
    (
        input  valid, status, ext_out, count_out, freed,
        output ready
    );
endinterface

FILE: design/rkt_ctrl.sv
// Controller: sequences accept, slot scan and result write-back.
module rkt_ctrl
    import rkt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  rkt_stat_t stat,
    output rkt_cmd_t  cmd
);

    rkt_state_t state_reg;
    rkt_state_t state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.match || stat.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // output register must be free or draining this cycle
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

FILE: design/rkt_datapath.sv
// Datapath: slot memories, valid bits, scan pipeline and result register.
module rkt_datapath
    import rkt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  rkt_cmd_t           cmd,
    output rkt_stat_t          stat,
    input  logic [1:0]         func,
    input  logic [63:0]        key,
    input  logic [63:0]        ext_value,
    input  logic signed [31:0] delta,
    output logic [1:0]         status,
    output logic [63:0]        ext_out,
    output logic [63:0]        count_out,
    output logic               freed
);

    logic [63:0] key_mem   [ENTRIES];
    logic [63:0] ext_mem   [ENTRIES];
    logic [63:0] count_mem [ENTRIES];

    logic [ENTRIES-1:0] valid_reg;

    logic [1:0]         func_reg;
    logic [63:0]        key_reg;
    logic [63:0]        ext_reg;
    logic signed [31:0] delta_reg;

    logic [IDX_W-1:0] cnt_reg;
    logic             issue_done_reg;
    logic             rd_en_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [63:0]      key_rd_reg;
    logic [63:0]      ext_rd_reg;
    logic [63:0]      count_rd_reg;

    logic             found_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [63:0]      hit_ext_reg;
    logic [63:0]      hit_count_reg;

    logic [1:0]  status_reg;
    logic [63:0] ext_out_reg;
    logic [63:0] count_out_reg;
    logic        freed_reg;

    logic             issue;
    logic             match_now;
    logic             free_now;
    logic [63:0]      sum_count;

    logic [1:0]       res_status;
    logic [63:0]      res_ext;
    logic [63:0]      res_count;
    logic             res_freed;
    logic             wr_key;
    logic             wr_count;
    logic [IDX_W-1:0] wr_idx;
    logic [63:0]      wr_count_val;
    logic             set_valid;
    logic             clr_valid;

    assign issue     = cmd.scan && !issue_done_reg;
    assign match_now = rd_en_reg && valid_reg[rd_idx_reg] && (key_rd_reg == key_reg);
    assign free_now  = rd_en_reg && !valid_reg[rd_idx_reg] && !free_found_reg;
    assign sum_count = hit_count_reg + {{32{delta_reg[31]}}, delta_reg};

    assign stat.match = match_now;
    assign stat.last  = rd_en_reg && (rd_idx_reg == IDX_W'(ENTRIES - 1));

    always_comb
    begin
        res_status   = STAT_DONE;
        res_ext      = '0;
        res_count    = '0;
        res_freed    = 1'b0;
        wr_key       = 1'b0;
        wr_count     = 1'b0;
        wr_idx       = hit_idx_reg;
        wr_count_val = sum_count;
        set_valid    = 1'b0;
        clr_valid    = 1'b0;
        unique case (func_reg)
            FUNC_INSERT:
            begin
                wr_idx       = free_idx_reg;
                wr_count_val = '0;
                if (found_reg)
                begin
                    res_status = STAT_DUPLICATE;
                end
                else if (!free_found_reg)
                begin
                    res_status = STAT_FULL;
                end
                else
                begin
                    wr_key    = 1'b1;
                    wr_count  = 1'b1;
                    set_valid = 1'b1;
                end
            end
            FUNC_LOOKUP:
            begin
                if (found_reg)
                begin
                    res_ext   = hit_ext_reg;
                    res_count = hit_count_reg;
                end
                else
                begin
                    res_status = STAT_MISSING;
                end
            end
            FUNC_UPDATE:
            begin
                if (found_reg)
                begin
                    res_count = sum_count;
                    wr_count  = 1'b1;
                    if (sum_count == '0)
                    begin
                        clr_valid = 1'b1;
                        res_freed = 1'b1;
                    end
                end
                else
                begin
                    res_status = STAT_MISSING;
                end
            end
            default:
            begin
                res_status = STAT_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            cnt_reg        <= '0;
            issue_done_reg <= 1'b0;
            rd_en_reg      <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                cnt_reg        <= '0;
                issue_done_reg <= 1'b0;
                rd_en_reg      <= 1'b0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                rd_en_reg <= issue;
                if (issue)
                begin
                    cnt_reg <= cnt_reg + IDX_W'(1);
                    if (cnt_reg == IDX_W'(ENTRIES - 1))
                    begin
                        issue_done_reg <= 1'b1;
                    end
                end
                if (match_now)
                begin
                    found_reg <= 1'b1;
                end
                if (free_now)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            else
            begin
                rd_en_reg <= 1'b0;
            end

            if (cmd.finish && set_valid)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            else if (cmd.finish && clr_valid)
            begin
                valid_reg[wr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            func_reg  <= func;
            key_reg   <= key;
            ext_reg   <= ext_value;
            delta_reg <= delta;
        end
        if (issue)
        begin
            rd_idx_reg   <= cnt_reg;
            key_rd_reg   <= key_mem[cnt_reg];
            ext_rd_reg   <= ext_mem[cnt_reg];
            count_rd_reg <= count_mem[cnt_reg];
        end
        if (cmd.scan && match_now)
        begin
            hit_idx_reg   <= rd_idx_reg;
            hit_ext_reg   <= ext_rd_reg;
            hit_count_reg <= count_rd_reg;
        end
        if (cmd.scan && free_now)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (cmd.finish)
        begin
            status_reg    <= res_status;
            ext_out_reg   <= res_ext;
            count_out_reg <= res_count;
            freed_reg     <= res_freed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish && wr_key)
        begin
            key_mem[wr_idx] <= key_reg;
            ext_mem[wr_idx] <= ext_reg;
        end
        if (cmd.finish && wr_count)
        begin
            count_mem[wr_idx] <= wr_count_val;
        end
    end

    assign status    = status_reg;
    assign ext_out   = ext_out_reg;
    assign count_out = count_out_reg;
    assign freed     = freed_reg;

endmodule

FILE: design/refcounted_key_table.sv
// Top level of the reference-counted key table.
//
// req (sink): one beat per operation: func, key, ext_value, delta.
// rsp (source): one beat per operation: status, ext_out, count_out, freed.
// Beats move when valid and ready are both high.
//
// Each operation scans the slots one per cycle through a single read port of
// the slot memories, stopping early on a key match. A hit ends the scan at the
// matching slot; a miss or a new insert scans all ENTRIES slots (64 entries).
// One operation is in flight at a time; req.ready is high only between
// operations, so a new request is not taken until the last one has finished.
//
// The response sits in an output register, so the next request is taken while
// an earlier response still waits. If rsp.ready stays low, the next operation
// holds in its final step until the register drains.
//
// Reset clears every slot's valid bit at once; the table is usable as soon as
// reset is released.
module refcounted_key_table
    import rkt_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    rkt_req_if.sink   req,
    rkt_rsp_if.source rsp
);

    rkt_cmd_t  cmd;
    rkt_stat_t stat;

    rkt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rkt_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .func      (req.func),
        .key       (req.key),
        .ext_value (req.ext_value),
        .delta     (req.delta),
        .status    (rsp.status),
        .ext_out   (rsp.ext_out),
        .count_out (rsp.count_out),
        .freed     (rsp.freed)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while an operation is in flight");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!rsp.valid || rsp.ready))
        else $error("result written over an undelivered response");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> rsp.valid)
        else $error("finished operation gave no response");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.scan, cmd.finish}))
        else $error("more than one datapath command at once");

endmodule
